/* rtl/sllm_pkg.sv */
// shared types and constants for the static linked list manager
package sllm_pkg;

    // field widths of the request and response words
    localparam int OP_W   = 2;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 6;

    // request kinds
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LENGTH = 2'd2
    } opcode_t;

    // response codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_FREE,
        S_INS_POP,
        S_WALK,
        S_WALK_RD,
        S_LINK,
        S_INS_SPLICE,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_DEL_PUSH,
        S_DONE
    } fsm_state_t;

endpackage

/* rtl/static_linked_list_manager.sv */
// Cursor-linked list in a fixed slot array. Slot 0 heads the free chain and slot SLOTS-1 heads
// the data list, so up to SLOTS-2 bytes are held. Each request word carries an opcode in tuser
// (insert before, delete at, or report length) and a 1-based position and data byte in tdata;
// each gets exactly one response word with a status in tuser and the element count in tdata.
// After reset a clearing pass rebuilds the free chain in the link memory, one slot per cycle;
// no request is taken until it is done. All links live in one synchronous memory with a
// registered read. Each hop of the walk to the predecessor issues a read in S_WALK and takes
// the successor in S_WALK_RD. A response that cannot be handed over holds the sequencer in
// S_DONE until the output register is free. The next request is accepted as soon as the
// sequencer is idle, even while the previous response still waits in the output register.
module static_linked_list_manager #(
    parameter int SLOTS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request: tuser[1:0] opcode
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [sllm_pkg::OP_W-1:0]    s_axis_tuser,
    // request: tdata[5:0] position, tdata[13:6] value, tdata[15:14] zero
    input  logic [15:0]                  s_axis_tdata,
    // response: tuser[1:0] status
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [sllm_pkg::STAT_W-1:0]  m_axis_tuser,
    // response: tdata[5:0] length, tdata[7:6] zero
    output logic [7:0]                   m_axis_tdata
);
    import sllm_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int EW = ((AW > POS_W) ? AW : POS_W) + 1;
    localparam logic [AW-1:0] HEAD_IDX = AW'(SLOTS - 1);
    localparam logic [AW-1:0] LAST_FREE = AW'(SLOTS - 2);
    localparam logic [AW-1:0] FREE_IDX = '0;

    // link and data memories
    logic [AW-1:0]    link_mem [SLOTS];
    logic [VAL_W-1:0] data_mem [SLOTS];
    logic [AW-1:0]    rd_data_reg;

    // memory port controls
    logic             lk_rd;
    logic [AW-1:0]    lk_raddr;
    logic             lk_we;
    logic [AW-1:0]    lk_waddr;
    logic [AW-1:0]    lk_wdata;
    logic             dt_we;

    // sequencer registers
    fsm_state_t       state_reg, state_next;
    opcode_t          op_reg, op_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [AW-1:0]    j_reg, j_next;
    logic [AW-1:0]    k_reg, k_next;
    logic [POS_W-1:0] n_reg, n_next;
    logic [AW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    clr_reg, clr_next;
    status_t          stat_reg, stat_next;

    // output register
    logic             m_valid_reg;
    status_t          m_status_reg;
    logic [LEN_W-1:0] m_len_reg;
    logic             out_load;

    // request fields
    opcode_t          in_op;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [EW-1:0]    pos_ext;
    logic [EW-1:0]    cnt_ext;
    logic             ins_bad;
    logic             del_bad;

    assign in_op   = opcode_t'(s_axis_tuser);
    assign in_pos  = s_axis_tdata[POS_W-1:0];
    assign in_val  = s_axis_tdata[POS_W+VAL_W-1:POS_W];
    assign pos_ext = EW'(in_pos);
    assign cnt_ext = EW'(cnt_reg);
    assign ins_bad = (in_pos == '0) || (pos_ext > cnt_ext + EW'(1));
    assign del_bad = (in_pos == '0) || (pos_ext > cnt_ext);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {{(8 - LEN_W){1'b0}}, m_len_reg};

    // link memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        if (lk_rd)
        begin
            rd_data_reg <= link_mem[lk_raddr];
        end
    end

    // data memory, written on each insert that takes a free slot
    always_ff @(posedge clk)
    begin
        if (dt_we)
        begin
            data_mem[j_reg] <= val_reg;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    // request payload and walk registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        n_reg    <= n_next;
        stat_reg <= stat_next;
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_status_reg <= stat_reg;
            m_len_reg    <= LEN_W'(cnt_reg);
        end
    end

    // sequencer: next state and memory accesses
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        stat_next  = stat_reg;
        lk_rd      = 1'b0;
        lk_raddr   = k_reg;
        lk_we      = 1'b0;
        lk_waddr   = k_reg;
        lk_wdata   = j_reg;
        dt_we      = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            // rebuild free chain: i to i+1, last free slot and list head to 0
            S_CLEAR:
            begin
                lk_we    = 1'b1;
                lk_waddr = clr_reg;
                lk_wdata = (clr_reg < LAST_FREE) ? clr_reg + AW'(1) : '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == HEAD_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            // take a request and check its position
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next   = in_op;
                    pos_next  = in_pos;
                    val_next  = in_val;
                    k_next    = HEAD_IDX;
                    n_next    = POS_W'(1);
                    stat_next = STAT_OK;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (ins_bad)
                            begin
                                stat_next  = STAT_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                lk_rd      = 1'b1;
                                lk_raddr   = FREE_IDX;
                                state_next = S_INS_FREE;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (del_bad)
                            begin
                                stat_next  = STAT_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // first free slot arrives
            S_INS_FREE:
            begin
                j_next = rd_data_reg;
                if (rd_data_reg == '0)
                begin
                    stat_next  = STAT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    lk_rd      = 1'b1;
                    lk_raddr   = rd_data_reg;
                    state_next = S_INS_POP;
                end
            end

            // pop the slot off the free chain and store the byte
            S_INS_POP:
            begin
                lk_we      = 1'b1;
                lk_waddr   = FREE_IDX;
                lk_wdata   = rd_data_reg;
                dt_we      = 1'b1;
                state_next = S_WALK;
            end

            // hop along the data list until the predecessor is reached
            S_WALK:
            begin
                lk_rd    = 1'b1;
                lk_raddr = k_reg;
                if (n_reg < pos_reg)
                begin
                    n_next     = n_reg + POS_W'(1);
                    state_next = S_WALK_RD;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end

            S_WALK_RD:
            begin
                k_next     = rd_data_reg;
                state_next = S_WALK;
            end

            // successor of the predecessor is in the read register
            S_LINK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    lk_we      = 1'b1;
                    lk_waddr   = j_reg;
                    lk_wdata   = rd_data_reg;
                    state_next = S_INS_SPLICE;
                end
                else
                begin
                    j_next     = rd_data_reg;
                    lk_rd      = 1'b1;
                    lk_raddr   = rd_data_reg;
                    state_next = S_DEL_UNLINK;
                end
            end

            S_INS_SPLICE:
            begin
                lk_we      = 1'b1;
                lk_waddr   = k_reg;
                lk_wdata   = j_reg;
                cnt_next   = cnt_reg + AW'(1);
                state_next = S_DONE;
            end

            // bypass the removed slot and fetch the free head
            S_DEL_UNLINK:
            begin
                lk_we      = 1'b1;
                lk_waddr   = k_reg;
                lk_wdata   = rd_data_reg;
                lk_rd      = 1'b1;
                lk_raddr   = FREE_IDX;
                state_next = S_DEL_FREE;
            end

            S_DEL_FREE:
            begin
                lk_we      = 1'b1;
                lk_waddr   = j_reg;
                lk_wdata   = rd_data_reg;
                state_next = S_DEL_PUSH;
            end

            // removed slot becomes the free head
            S_DEL_PUSH:
            begin
                lk_we      = 1'b1;
                lk_waddr   = FREE_IDX;
                lk_wdata   = j_reg;
                cnt_next   = cnt_reg - AW'(1);
                state_next = S_DONE;
            end

            // hand the response to the output register once it is free
            S_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // element count never exceeds the usable slots
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_FREE)
        else $error("element count above capacity");

    // no response while the free chain is still being built
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !m_valid_reg)
        else $error("response during clearing pass");

    // the walk never passes the requested position
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> n_reg <= pos_reg && pos_reg != '0)
        else $error("walk counter beyond position");

    // the predecessor is never the free chain head
    a_pred_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |-> k_reg != FREE_IDX)
        else $error("predecessor is the free head");

    // a delete shrinks the list by exactly one
    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEL_PUSH |=> cnt_reg == $past(cnt_reg) - AW'(1))
        else $error("delete did not decrement count");
`endif

endmodule

/* test/list_checker.sv */
// request/response monitor with a slot-level model of the linked list and its free chain
module list_checker #(
    parameter int SLOTS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    // request: tuser[1:0] opcode
    input  logic [sllm_pkg::OP_W-1:0]    s_axis_tuser,
    // request: tdata[5:0] position, tdata[13:6] value, tdata[15:14] zero
    input  logic [15:0]                  s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // response: tuser[1:0] status
    input  logic [sllm_pkg::STAT_W-1:0]  m_axis_tuser,
    // response: tdata[5:0] length, tdata[7:6] zero
    input  logic [7:0]                   m_axis_tdata,
    output int                           mismatch_count,
    output int                           replies_pending,
    output int                           list_length,
    output int                           replies_seen,
    output int                           range_seen,
    output int                           full_seen
);
    import sllm_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   length;
    } reply_t;

    // link memory: slot 0 heads the free chain, slot SLOTS-1 heads the data list;
    // stored bytes never reach a response, so only the links are tracked
    logic [SLOT_W-1:0] next_slot [SLOTS];
    int                element_total;
    reply_t            expected_replies [$];

    // follow the data list from its header to the slot in front of a 1-based position
    function automatic int slot_before(int pos);
        int k;
        int n;
        k = SLOTS - 1;
        for (n = 1; n < pos; n++)
            k = next_slot[k];
        return k;
    endfunction

    // apply one request to the list and return the response word it should produce
    function automatic reply_t apply_request(logic [OP_W-1:0] op, int pos);
        reply_t r;
        int     j;
        int     k;
        r.status = STAT_OK;
        if (op == OP_INSERT) begin
            if (pos < 1 || pos > element_total + 1)
                r.status = STAT_RANGE;
            else if (next_slot[0] == 0)
                r.status = STAT_FULL;
            else
            begin
                // pop the free head, then splice it in after the predecessor
                j = next_slot[0];
                next_slot[0] = next_slot[j];
                k = slot_before(pos);
                next_slot[j] = next_slot[k];
                next_slot[k] = SLOT_W'(j);
                element_total++;
            end
        end
        else if (op == OP_DELETE) begin
            if (pos < 1 || pos > element_total)
                r.status = STAT_RANGE;
            else
            begin
                // unlink the element and push its slot onto the free chain
                k = slot_before(pos);
                j = next_slot[k];
                next_slot[k] = next_slot[j];
                next_slot[j] = next_slot[0];
                next_slot[0] = SLOT_W'(j);
                element_total--;
            end
        end
        r.length = LEN_W'(element_total);
        return r;
    endfunction

    // responses are checked before the request of the same edge is modeled
    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                next_slot[i] = (i < SLOTS - 2) ? SLOT_W'(i + 1) : '0;
            element_total = 0;
            expected_replies.delete();
            mismatch_count = 0;
            replies_pending = 0;
            list_length = 0;
            replies_seen = 0;
            range_seen = 0;
            full_seen = 0;
        end
        else
        begin
            // compare a response word against the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("response word with nothing pending: status %0d length %0d",
                           m_axis_tuser, m_axis_tdata[LEN_W-1:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[LEN_W-1:0] !== want.length) begin
                        $error("length mismatch: expected %0d, actual %0d",
                               want.length, m_axis_tdata[LEN_W-1:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[7:LEN_W] !== '0) begin
                        $error("pad mismatch: expected 0, actual %0d",
                               m_axis_tdata[7:LEN_W]);
                        mismatch_count++;
                    end
                    replies_seen++;
                    if (want.status == STAT_RANGE)
                        range_seen++;
                    if (want.status == STAT_FULL)
                        full_seen++;
                end
            end

            // model an accepted request word
            if (s_axis_tvalid && s_axis_tready)
                expected_replies.push_back(
                    apply_request(s_axis_tuser, int'(s_axis_tdata[POS_W-1:0])));

            replies_pending = expected_replies.size();
            list_length = element_total;
        end
    end

endmodule

/* test/tb.sv */
// stimulus, clock, reset and verdict for the static linked list manager
module tb;
    import sllm_pkg::*;

    localparam int SLOTS          = 64;
    localparam int RANDOM_WORDS   = 1200;
    localparam int PHASE_WORDS    = 150;
    localparam int QUIET_WORDS    = 150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 2 * SLOTS + 16;

    // opcode 3 has no name in the package and behaves as a length report
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum int {
        PH_FILL,
        PH_MIX_A,
        PH_DRAIN,
        PH_MIX_B
    } phase_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [OP_W-1:0]     s_axis_tuser = '0;    // opcode
    logic [15:0]         s_axis_tdata = '0;    // position, value, zero pad
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [STAT_W-1:0]   m_axis_tuser;         // status
    logic [7:0]          m_axis_tdata;         // length, zero pad

    logic                quiet = 1'b0;
    int                  idle_cycles = 0;

    int                  mismatch_count;
    int                  replies_pending;
    int                  list_length;
    int                  replies_seen;
    int                  range_seen;
    int                  full_seen;

    static_linked_list_manager #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tuser,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tuser,
        .m_axis_tdata
    );

    list_checker #(
        .SLOTS(SLOTS)
    ) list_check (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tuser,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tuser,
        .m_axis_tdata,
        .mismatch_count,
        .replies_pending,
        .list_length,
        .replies_seen,
        .range_seen,
        .full_seen
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // present one request word at a falling edge, after an occasional random idle gap unless quiet,
    // hold it until taken, and return at the next falling edge
    task automatic send_word(input logic [OP_W-1:0] op, input int pos,
                             input logic [VAL_W-1:0] val);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {2'b00, val, POS_W'(pos)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // response side stalls in random bursts unless quiet
    initial
    begin
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // main sequence
    initial
    begin
        int             n;
        int             roll;
        int             cnt;
        int             pos;
        int             ins_share;
        int             del_share;
        int             peak;
        logic [OP_W-1:0] op;
        phase_t         phase;

        peak = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, unused opcode, range edges, head/middle/tail edits
        send_word(OP_LENGTH, 0, 8'h00);
        send_word(OP_UNUSED, 63, 8'hFF);
        send_word(OP_DELETE, 1, 8'h00);
        send_word(OP_INSERT, 0, 8'h11);
        send_word(OP_INSERT, 2, 8'h22);
        send_word(OP_INSERT, 1, 8'h00);
        send_word(OP_INSERT, 1, 8'hFF);
        send_word(OP_INSERT, 3, 8'hAA);
        send_word(OP_INSERT, 2, 8'h55);
        send_word(OP_INSERT, 63, 8'h7E);
        send_word(OP_DELETE, 0, 8'h00);
        send_word(OP_DELETE, 5, 8'h00);
        send_word(OP_DELETE, 63, 8'hFF);
        send_word(OP_DELETE, 4, 8'h00);
        send_word(OP_DELETE, 1, 8'h00);
        send_word(OP_INSERT, 3, 8'h3C);
        send_word(OP_DELETE, 2, 8'h00);
        send_word(OP_LENGTH, 63, 8'hFF);
        send_word(OP_INSERT, 1, 8'h81);
        send_word(OP_DELETE, 3, 8'h00);
        send_word(OP_DELETE, 1, 8'h00);
        send_word(OP_DELETE, 1, 8'h00);
        send_word(OP_DELETE, 1, 8'h00);

        // hold off until every response is back
        s_axis_tvalid = 1'b0;
        do
            @(negedge clk);
        while (replies_pending != 0);

        // random: fill to full, mixed, drain to empty, mixed, repeated
        for (n = 0; n < RANDOM_WORDS; n++) begin
            phase = phase_t'((n / PHASE_WORDS) % 4);
            quiet = (n >= RANDOM_WORDS - QUIET_WORDS);
            cnt = list_length;
            if (cnt > peak)
                peak = cnt;
            case (phase)
                PH_FILL:
                begin
                    ins_share = 85;
                    del_share = 5;
                end
                PH_DRAIN:
                begin
                    ins_share = 5;
                    del_share = 85;
                end
                default:
                begin
                    ins_share = 45;
                    del_share = 40;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_share) begin
                op = OP_INSERT;
                pos = $urandom_range(1, cnt + 1);
            end
            else if (roll < ins_share + del_share) begin
                op = OP_DELETE;
                pos = (cnt == 0) ? 1 : $urandom_range(1, cnt);
            end
            else
            begin
                // noise: any opcode, any position
                op = OP_W'($urandom_range(0, 3));
                pos = $urandom_range(0, 63);
            end
            send_word(op, pos, VAL_W'($urandom_range(0, 255)));
        end
        s_axis_tvalid = 1'b0;

        // drain and settle
        while (replies_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("checked %0d response words: %0d out-of-range and %0d store-full rejections",
                 replies_seen, range_seen, full_seen);
        $display("list length reached %0d of %0d usable slots", peak, SLOTS - 2);
        if (mismatch_count == 0 && replies_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/sllm_pkg.sv
rtl/static_linked_list_manager.sv
test/list_checker.sv
test/tb.sv
